FILE: src/rkd_pkg.sv
// shared types, codes and constants of the ring key and distance alu
package rkd_pkg;

  localparam int unsigned Words = 5;
  localparam int unsigned IdxW  = 3;

  typedef logic [0:Words-1][31:0] opv_t;
  typedef logic [IdxW-1:0]        idx_t;

  localparam logic [2:0] KZero     = 3'd0;
  localparam logic [2:0] KPinf     = 3'd1;
  localparam logic [2:0] KNinf     = 3'd2;
  localparam logic [2:0] KSigned   = 3'd3;
  localparam logic [2:0] KUnsigned = 3'd4;

  localparam logic [3:0] OpDiffSub  = 4'd0;
  localparam logic [3:0] OpDiffAdd  = 4'd1;
  localparam logic [3:0] OpDiffAddS = 4'd2;
  localparam logic [3:0] OpDiffSubS = 4'd3;
  localparam logic [3:0] OpLt       = 4'd4;
  localparam logic [3:0] OpLe       = 4'd5;
  localparam logic [3:0] OpEq       = 4'd6;
  localparam logic [3:0] OpSign     = 4'd7;
  localparam logic [3:0] OpAbs      = 4'd8;
  localparam logic [3:0] OpShr      = 4'd9;
  localparam logic [3:0] OpKeyKey   = 4'd10;
  localparam logic [3:0] OpKeyAdd   = 4'd11;
  localparam logic [3:0] OpKeySub   = 4'd12;
  localparam logic [3:0] OpKeyAddS  = 4'd13;
  localparam logic [3:0] OpKeySubS  = 4'd14;
  localparam logic [3:0] OpNone     = 4'd15;

  localparam logic [1:0] ErrOk    = 2'd0;
  localparam logic [1:0] ErrInf   = 2'd1;
  localparam logic [1:0] ErrZeroK = 2'd2;

  typedef struct packed {
    logic        is_exec;
    idx_t        idx;
    logic [31:0] a_word;
    logic [31:0] b_word;
    logic [3:0]  op;
    logic [2:0]  ka;
    logic [2:0]  kb;
    logic [31:0] small_val;
    logic [8:0]  shift;
  } item_t;

endpackage

FILE: src/rkd_front.sv
// front stage: takes beats, normalises kinds, drops beats with no effect
module rkd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 cmd_i,
  input  logic [2:0]           word_index_i,
  input  logic [31:0]          a_word_i,
  input  logic [31:0]          b_word_i,
  input  logic [3:0]           op_i,
  input  logic [2:0]           a_kind_i,
  input  logic [2:0]           b_kind_i,
  input  logic [31:0]          small_value_i,
  input  logic [8:0]           shift_amount_i,
  output logic                 push_o,
  output rkd_pkg::item_t       item_o,
  input  logic                 full_i
);
  import rkd_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  take, keep;

  assign busy   = valid_q && full_i;
  assign take   = start && !busy;
  assign push_o = valid_q && !full_i;

  always_comb begin
    item_d           = item_q;
    item_d.is_exec   = cmd_i;
    item_d.idx       = word_index_i;
    item_d.a_word    = a_word_i;
    item_d.b_word    = b_word_i;
    item_d.op        = op_i;
    item_d.ka        = (a_kind_i > KUnsigned) ? KUnsigned : a_kind_i;
    item_d.kb        = (b_kind_i > KUnsigned) ? KUnsigned : b_kind_i;
    item_d.small_val = small_value_i;
    item_d.shift     = shift_amount_i;
    // loads beyond the operand and the unused op code do nothing
    keep = cmd_i ? (op_i != OpNone) : ({1'b0, word_index_i} < (IdxW + 1)'(Words));
    valid_d = valid_q && !push_o;
    if (take) begin
      valid_d = keep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

FILE: src/rkd_queue.sv
// two-entry queue between front and back
module rkd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rkd_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output rkd_pkg::item_t item_o
);
  import rkd_pkg::*;

  item_t      mem_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign item_o  = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q ^ push_i;
    rp_d  = rp_q ^ pop_i;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= item_i;
    end
  end

endmodule

FILE: src/rkd_back.sv
// back end: operand store, compare scan and word-serial add/subtract
module rkd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  rkd_pkg::item_t      item_i,
  output logic                pop_o,
  output logic                result_valid_o,
  output logic [31:0]         result_word_o,
  output logic [2:0]          result_index_o,
  output logic                last_o,
  output logic [2:0]          result_kind_o,
  output logic                flag_o,
  output logic signed [1:0]   sign_value_o,
  output logic [1:0]          error_o
);
  import rkd_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDec  = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  localparam logic [1:0] ActNone  = 2'd0;
  localparam logic [1:0] ActOne   = 2'd1;
  localparam logic [1:0] ActWords = 2'd2;

  localparam logic [1:0] XA    = 2'd0;
  localparam logic [1:0] XZero = 2'd1;
  localparam logic [1:0] XShr  = 2'd2;

  localparam logic [1:0] YB     = 2'd0;
  localparam logic [1:0] YA     = 2'd1;
  localparam logic [1:0] YSmall = 2'd2;
  localparam logic [1:0] YZero  = 2'd3;

  localparam idx_t LastIdx = IdxW'(Words - 1);

  logic [1:0]  st_q, st_d;
  idx_t        cnt_q, cnt_d;
  logic        cy_q, cy_d;
  item_t       ex_q;
  opv_t        a_q, b_q, shr_q;
  logic        eq_q, eq_d, anz_q, anz_d, dnz_q, dnz_d, dmsb_q, dmsb_d;
  logic [1:0]  xs_q, ys_q;
  logic        sub_q;
  logic [2:0]  wk_q;

  logic        rv_d;
  logic [31:0] rw_d;
  idx_t        ri_d;
  logic        rl_d;
  logic [2:0]  rk_d;
  logic        rf_d;
  logic [1:0]  rs_d, re_d;

  logic [31:0] sx, sy, ex, ey;
  logic [32:0] sdiff, esum;

  logic [1:0]  act;
  logic [2:0]  okind, wkind;
  logic        oflag, osub, lt_c, eq_c, dequal, ainf, binf;
  logic [1:0]  osgn, oerr, oxs, oys, sgn_a;

  assign pop_o = (st_q == StIdle) && !empty_i;

  // scan datapath: compare subtraction and equality
  always_comb begin
    sx    = (ex_q.ka == KZero) ? 32'd0 : a_q[cnt_q];
    sy    = (ex_q.kb == KZero) ? 32'd0 : b_q[cnt_q];
    sdiff = {1'b0, sx} - {1'b0, sy} - {32'd0, cy_q};
  end

  // emit datapath
  always_comb begin
    case (xs_q)
      XA:      ex = a_q[cnt_q];
      XShr:    ex = shr_q[cnt_q];
      default: ex = 32'd0;
    endcase
    case (ys_q)
      YB:      ey = b_q[cnt_q];
      YA:      ey = a_q[cnt_q];
      YSmall:  ey = (cnt_q == LastIdx) ? ex_q.small_val : 32'd0;
      default: ey = 32'd0;
    endcase
    if (sub_q) begin
      esum = {1'b0, ex} - {1'b0, ey} - {32'd0, cy_q};
    end else begin
      esum = {1'b0, ex} + {1'b0, ey} + {32'd0, cy_q};
    end
  end

  // outcome of an execute beat from the scan flags
  always_comb begin
    ainf   = (ex_q.ka == KPinf) || (ex_q.ka == KNinf);
    binf   = (ex_q.kb == KPinf) || (ex_q.kb == KNinf);
    dequal = (ainf || binf) ? 1'b0 :
             ((ex_q.ka == KZero) || (ex_q.kb == KZero)) ? (ex_q.ka == ex_q.kb) : eq_q;
    if ((ex_q.ka == KUnsigned) && (ex_q.kb == KUnsigned)) begin
      lt_c = cy_q;
      eq_c = eq_q;
    end else begin
      lt_c = dnz_q && dmsb_q;
      eq_c = !dnz_q;
    end
    if (ex_q.ka == KZero) begin
      sgn_a = 2'b00;
    end else if (ex_q.ka == KPinf) begin
      sgn_a = 2'b01;
    end else if (ex_q.ka == KNinf) begin
      sgn_a = 2'b11;
    end else if (!anz_q) begin
      sgn_a = 2'b00;
    end else if (ex_q.ka == KUnsigned) begin
      sgn_a = 2'b01;
    end else begin
      sgn_a = a_q[0][31] ? 2'b11 : 2'b01;
    end
    act   = ActWords;
    okind = KZero;
    oflag = 1'b0;
    osgn  = 2'b00;
    oerr  = ErrOk;
    oxs   = XA;
    oys   = YZero;
    osub  = 1'b0;
    wkind = ex_q.ka;
    case (ex_q.op)
      OpDiffSub: begin
        if (dequal) begin
          act = ActOne;
        end else if (ainf) begin
          act = ActOne; okind = ex_q.ka;
        end else if (ex_q.kb == KPinf) begin
          act = ActOne; okind = KNinf;
        end else if (ex_q.kb == KNinf) begin
          act = ActOne; okind = KPinf;
        end else if (ex_q.kb == KZero) begin
          oys = YZero;
        end else if (ex_q.ka == KZero) begin
          oxs = XZero; oys = YB; osub = 1'b1; wkind = KSigned;
        end else begin
          oys = YB; osub = 1'b1;
        end
      end
      OpDiffAdd: begin
        if (ainf) begin
          act = ActOne; okind = ex_q.ka;
        end else if (binf) begin
          act = ActOne; okind = ex_q.kb;
        end else if (ex_q.kb == KZero) begin
          oys = YZero;
        end else if (ex_q.ka == KZero) begin
          oxs = XZero; oys = YB; wkind = ex_q.kb;
        end else begin
          oys = YB;
        end
      end
      OpDiffAddS, OpDiffSubS: begin
        if (ainf) begin
          act = ActOne; okind = ex_q.ka;
        end else if (ex_q.small_val == 32'd0) begin
          oys = YZero;
        end else if (ex_q.ka == KZero) begin
          act = ActOne; oerr = ErrZeroK;
        end else begin
          oys = YSmall; osub = ex_q.op == OpDiffSubS;
        end
      end
      OpLt, OpLe: begin
        act = ActOne;
        if ((ex_q.kb == KPinf) || (ex_q.ka == KNinf)) begin
          oflag = 1'b1;
        end else if ((ex_q.ka == KPinf) || (ex_q.kb == KNinf)) begin
          oflag = 1'b0;
        end else begin
          oflag = (ex_q.op == OpLt) ? lt_c : (lt_c || eq_c);
        end
      end
      OpEq: begin
        act = ActOne; oflag = dequal;
      end
      OpSign: begin
        act = ActOne; osgn = sgn_a;
      end
      OpAbs: begin
        if (ex_q.ka == KNinf) begin
          act = ActOne; okind = KPinf;
        end else if ((ex_q.ka == KSigned) && (sgn_a == 2'b11)) begin
          oxs = XZero; oys = YA; osub = 1'b1;
        end
      end
      OpShr: begin
        oxs = XShr;
      end
      OpKeyKey: begin
        if (eq_q) begin
          act = ActOne;
        end else begin
          oys = YB; osub = 1'b1; wkind = KUnsigned;
        end
      end
      OpKeyAdd, OpKeySub: begin
        if (binf) begin
          act = ActOne; oerr = ErrInf;
        end else begin
          wkind = KUnsigned;
          oys   = (ex_q.kb == KZero) ? YZero : YB;
          osub  = ex_q.op == OpKeySub;
        end
      end
      OpKeyAddS, OpKeySubS: begin
        oys = YSmall; osub = ex_q.op == OpKeySubS; wkind = KUnsigned;
      end
      default: begin
        act = ActNone;
      end
    endcase
    // words of a zero or infinite kind collapse to one beat
    if ((act == ActWords) && (wkind <= KNinf)) begin
      act   = ActOne;
      okind = wkind;
    end
  end

  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    cy_d   = cy_q;
    eq_d   = eq_q;
    anz_d  = anz_q;
    dnz_d  = dnz_q;
    dmsb_d = dmsb_q;
    rv_d   = 1'b0;
    rw_d   = 32'd0;
    ri_d   = '0;
    rl_d   = 1'b1;
    rk_d   = KZero;
    rf_d   = 1'b0;
    rs_d   = 2'b00;
    re_d   = ErrOk;
    case (st_q)
      StIdle: begin
        if (pop_o && item_i.is_exec) begin
          st_d   = StScan;
          cnt_d  = LastIdx;
          cy_d   = 1'b0;
          eq_d   = 1'b1;
          anz_d  = 1'b0;
          dnz_d  = 1'b0;
          dmsb_d = 1'b0;
        end
      end
      StScan: begin
        cy_d  = sdiff[32];
        eq_d  = eq_q && (a_q[cnt_q] == b_q[cnt_q]);
        anz_d = anz_q || (a_q[cnt_q] != 32'd0);
        dnz_d = dnz_q || (sdiff[31:0] != 32'd0);
        if (cnt_q == '0) begin
          dmsb_d = sdiff[31];
          st_d   = StDec;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StDec: begin
        cnt_d = LastIdx;
        cy_d  = 1'b0;
        if (act == ActWords) begin
          st_d = StEmit;
        end else begin
          st_d = StIdle;
          rv_d = act == ActOne;
          rk_d = okind;
          rf_d = oflag;
          rs_d = osgn;
          re_d = oerr;
        end
      end
      default: begin
        rv_d = 1'b1;
        rw_d = esum[31:0];
        ri_d = cnt_q;
        rl_d = cnt_q == '0;
        rk_d = wk_q;
        cy_d = esum[32];
        if (cnt_q == '0) begin
          st_d = StIdle;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q           <= StIdle;
      result_valid_o <= 1'b0;
    end else begin
      st_q           <= st_d;
      result_valid_o <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q          <= cnt_d;
    cy_q           <= cy_d;
    eq_q           <= eq_d;
    anz_q          <= anz_d;
    dnz_q          <= dnz_d;
    dmsb_q         <= dmsb_d;
    result_word_o  <= rw_d;
    result_index_o <= ri_d;
    last_o         <= rl_d;
    result_kind_o  <= rk_d;
    flag_o         <= rf_d;
    sign_value_o   <= rs_d;
    error_o        <= re_d;
    if (pop_o) begin
      if (item_i.is_exec) begin
        ex_q  <= item_i;
        shr_q <= opv_t'(a_q >> item_i.shift);
      end else begin
        a_q[item_i.idx] <= item_i.a_word;
        b_q[item_i.idx] <= item_i.b_word;
      end
    end
    if (st_q == StDec) begin
      xs_q  <= oxs;
      ys_q  <= oys;
      sub_q <= osub;
      wk_q  <= wkind;
    end
  end

endmodule

FILE: src/ring_key_distance_alu.sv
// top level of the ring key and distance alu
//
//  channel  | handshake               | beat
//  ---------+-------------------------+-------------------------------------------
//  command  | start / busy            | cmd, word index, operand words, op, kinds
//  result   | result_valid_o, 1 cycle | result word, index, last, kind, flag, sign
//
// a load is written to the operand store when the back end pops it; an execute
// is popped, scans all operand words, passes the decision state, then emits one
// result word per cycle, or a single beat straight from the decision state.
// a two-beat queue lets the front take beats while the back end works;
// busy rises only when the queue and the front register are full.
// reset clears control state only; operand words stay unknown until loaded.
module ring_key_distance_alu (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cmd_i,
  input  logic [2:0]         word_index_i,
  input  logic [31:0]        a_word_i,
  input  logic [31:0]        b_word_i,
  input  logic [3:0]         op_i,
  input  logic [2:0]         a_kind_i,
  input  logic [2:0]         b_kind_i,
  input  logic [31:0]        small_value_i,
  input  logic [8:0]         shift_amount_i,
  output logic               result_valid_o,
  output logic [31:0]        result_word_o,
  output logic [2:0]         result_index_o,
  output logic               last_o,
  output logic [2:0]         result_kind_o,
  output logic               flag_o,
  output logic signed [1:0]  sign_value_o,
  output logic [1:0]         error_o
);
  import rkd_pkg::*;

  logic  push, full, pop, empty;
  item_t f_item, q_item;

  rkd_front u_front (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .word_index_i, .a_word_i, .b_word_i,
    .op_i, .a_kind_i, .b_kind_i, .small_value_i, .shift_amount_i,
    .push_o (push), .item_o (f_item), .full_i (full)
  );

  rkd_queue u_queue (
    .clk_i, .rst_ni, .push_i (push), .item_i (f_item), .full_o (full),
    .pop_i (pop), .empty_o (empty), .item_o (q_item)
  );

  rkd_back u_back (
    .clk_i, .rst_ni, .empty_i (empty), .item_i (q_item), .pop_o (pop),
    .result_valid_o, .result_word_o, .result_index_o, .last_o,
    .result_kind_o, .flag_o, .sign_value_o, .error_o
  );

endmodule

FILE: test/ring_key_distance_alu_tb.sv
// self-checking testbench of the ring key and distance alu: directed and random command beats
module ring_key_distance_alu_tb;
  import rkd_pkg::*;

  typedef struct {
    logic        exec;
    logic [2:0]  idx;
    logic [31:0] aw;
    logic [31:0] bw;
    logic [3:0]  op;
    logic [2:0]  ka;
    logic [2:0]  kb;
    logic [31:0] sv;
    logic [8:0]  sh;
  } cmd_beat_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
    logic [2:0]  kind;
    logic        flag;
    logic [1:0]  sgn;
    logic [1:0]  err;
  } res_beat_t;

  localparam int Bits = 32 * Words;
  localparam int WatchLimit = 3000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cmd_i = 1'b0;
  logic [2:0] word_index_i = '0;
  logic [31:0] a_word_i = '0, b_word_i = '0, small_value_i = '0;
  logic [3:0] op_i = '0;
  logic [2:0] a_kind_i = '0, b_kind_i = '0;
  logic [8:0] shift_amount_i = '0;
  logic result_valid_o;
  logic [31:0] result_word_o;
  logic [2:0] result_index_o;
  logic last_o;
  logic [2:0] result_kind_o;
  logic flag_o;
  logic signed [1:0] sign_value_o;
  logic [1:0] error_o;

  logic [Bits-1:0] a_val = '0, b_val = '0;
  res_beat_t expected_q[$];
  int fails = 0;
  int idle_cycles = 0;
  bit gaps_on = 1'b1;

  ring_key_distance_alu dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [2:0] norm_kind(logic [2:0] k);
    return (k > KUnsigned) ? KUnsigned : k;
  endfunction

  function automatic int sign_of(logic [2:0] k, logic [Bits-1:0] v);
    if (k == KZero) return 0;
    if (k == KPinf) return 1;
    if (k == KNinf) return -1;
    if (v == '0) return 0;
    if (k == KUnsigned) return 1;
    return v[Bits-1] ? -1 : 1;
  endfunction

  function automatic bit dist_equal(logic [2:0] ka, logic [2:0] kb);
    if (ka == KPinf || ka == KNinf || kb == KPinf || kb == KNinf) return 1'b0;
    if (ka == KZero || kb == KZero) return ka == kb;
    return a_val == b_val;
  endfunction

  task automatic push_single(logic [2:0] kind, logic flag, int sgn, logic [1:0] err);
    res_beat_t r;
    r.word = '0; r.idx = '0; r.last = 1'b1; r.kind = kind; r.flag = flag;
    r.sgn = (sgn < 0) ? 2'b11 : 2'(sgn); r.err = err;
    expected_q.push_back(r);
  endtask

  task automatic push_words(logic [Bits-1:0] v, logic [2:0] kind);
    res_beat_t r;
    if (kind == KZero || kind == KPinf || kind == KNinf) begin
      push_single(kind, 1'b0, 0, ErrOk);
      return;
    end
    for (int i = Words - 1; i >= 0; i--) begin
      r.word = v[Bits-1-32*i -: 32]; r.idx = 3'(i); r.last = (i == 0);
      r.kind = kind; r.flag = 1'b0; r.sgn = 2'b00; r.err = ErrOk;
      expected_q.push_back(r);
    end
  endtask

  task automatic predict_results(cmd_beat_t c);
    logic [2:0] ka, kb;
    logic [Bits-1:0] x, y, d, s;
    int cmp;
    if (!c.exec) begin
      if (c.idx < Words) begin
        a_val[Bits-1-32*c.idx -: 32] = c.aw;
        b_val[Bits-1-32*c.idx -: 32] = c.bw;
      end
      return;
    end
    ka = norm_kind(c.ka);
    kb = norm_kind(c.kb);
    s = Bits'(c.sv);
    case (c.op)
      OpDiffSub: begin
        if (dist_equal(ka, kb)) push_single(KZero, 1'b0, 0, ErrOk);
        else if (ka == KPinf || ka == KNinf) push_single(ka, 1'b0, 0, ErrOk);
        else if (kb == KPinf) push_single(KNinf, 1'b0, 0, ErrOk);
        else if (kb == KNinf) push_single(KPinf, 1'b0, 0, ErrOk);
        else if (kb == KZero) push_words(a_val, ka);
        else if (ka == KZero) push_words(-b_val, KSigned);
        else push_words(a_val - b_val, ka);
      end
      OpDiffAdd: begin
        if (ka == KPinf || ka == KNinf) push_single(ka, 1'b0, 0, ErrOk);
        else if (kb == KPinf || kb == KNinf) push_single(kb, 1'b0, 0, ErrOk);
        else if (kb == KZero) push_words(a_val, ka);
        else if (ka == KZero) push_words(b_val, kb);
        else push_words(a_val + b_val, ka);
      end
      OpDiffAddS, OpDiffSubS: begin
        if (ka == KPinf || ka == KNinf) push_single(ka, 1'b0, 0, ErrOk);
        else if (c.sv == '0) push_words(a_val, ka);
        else if (ka == KZero) push_single(KZero, 1'b0, 0, ErrZeroK);
        else push_words((c.op == OpDiffSubS) ? a_val - s : a_val + s, ka);
      end
      OpLt, OpLe: begin
        if (kb == KPinf || ka == KNinf) push_single(KZero, 1'b1, 0, ErrOk);
        else if (ka == KPinf || kb == KNinf) push_single(KZero, 1'b0, 0, ErrOk);
        else begin
          if (ka == KUnsigned && kb == KUnsigned)
            cmp = (a_val < b_val) ? -1 : (a_val > b_val) ? 1 : 0;
          else begin
            x = (ka == KZero) ? '0 : a_val;
            y = (kb == KZero) ? '0 : b_val;
            d = x - y;
            cmp = sign_of(KSigned, d);
          end
          push_single(KZero, (c.op == OpLt) ? (cmp < 0) : (cmp <= 0), 0, ErrOk);
        end
      end
      OpEq: push_single(KZero, dist_equal(ka, kb), 0, ErrOk);
      OpSign: push_single(KZero, 1'b0, sign_of(ka, a_val), ErrOk);
      OpAbs: begin
        if (ka == KNinf) push_single(KPinf, 1'b0, 0, ErrOk);
        else if (ka == KSigned && sign_of(ka, a_val) < 0) push_words(-a_val, ka);
        else push_words(a_val, ka);
      end
      OpShr: push_words((c.sh >= Bits) ? '0 : a_val >> c.sh, ka);
      OpKeyKey: begin
        if (a_val == b_val) push_single(KZero, 1'b0, 0, ErrOk);
        else push_words(a_val - b_val, KUnsigned);
      end
      OpKeyAdd, OpKeySub: begin
        if (kb == KPinf || kb == KNinf) push_single(KZero, 1'b0, 0, ErrInf);
        else if (kb == KZero) push_words(a_val, KUnsigned);
        else push_words((c.op == OpKeyAdd) ? a_val + b_val : a_val - b_val, KUnsigned);
      end
      OpKeyAddS, OpKeySubS:
        push_words((c.op == OpKeySubS) ? a_val - s : a_val + s, KUnsigned);
      default: ;
    endcase
  endtask

  task automatic send_beat(cmd_beat_t c);
    start <= 1'b1;
    cmd_i <= c.exec; word_index_i <= c.idx; a_word_i <= c.aw; b_word_i <= c.bw;
    op_i <= c.op; a_kind_i <= c.ka; b_kind_i <= c.kb;
    small_value_i <= c.sv; shift_amount_i <= c.sh;
    do @(posedge clk_i); while (busy);
    predict_results(c);
  endtask

  task automatic idle_gap();
    int n;
    int p;
    p = $urandom_range(99);
    n = !gaps_on ? 0 : (p < 55) ? 0 : (p < 92) ? $urandom_range(3, 1) : $urandom_range(40, 8);
    if (n == 0) return;
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_beat_t load_beat(int idx, logic [31:0] aw, logic [31:0] bw);
    cmd_beat_t c;
    c.exec = 1'b0; c.idx = 3'(idx); c.aw = aw; c.bw = bw;
    c.op = 4'($urandom); c.ka = 3'($urandom); c.kb = 3'($urandom);
    c.sv = $urandom; c.sh = 9'($urandom);
    return c;
  endfunction

  function automatic cmd_beat_t exec_beat(logic [3:0] op, logic [2:0] ka, logic [2:0] kb,
                                          logic [31:0] sv, logic [8:0] sh);
    cmd_beat_t c;
    c.exec = 1'b1; c.idx = 3'($urandom); c.aw = $urandom; c.bw = $urandom;
    c.op = op; c.ka = ka; c.kb = kb; c.sv = sv; c.sh = sh;
    return c;
  endfunction

  task automatic load_all(logic [31:0] aw, logic [31:0] bw);
    for (int i = 0; i < Words; i++) begin
      send_beat(load_beat(i, aw, bw));
      idle_gap();
    end
  endtask

  task automatic test_extreme_words();
    load_all(32'hffff_ffff, 32'h0);
    send_beat(load_beat(7, 32'h1234_5678, 32'h9abc_def0));
    send_beat(exec_beat(OpDiffAdd, KUnsigned, KUnsigned, 32'h0, 9'd0));
    send_beat(exec_beat(OpKeyAddS, KUnsigned, KUnsigned, 32'hffff_ffff, 9'd0));
    send_beat(exec_beat(OpShr, KSigned, KZero, 32'h0, 9'd256));
    send_beat(exec_beat(OpShr, KUnsigned, KZero, 32'h0, 9'd33));
    send_beat(exec_beat(OpNone, KUnsigned, KUnsigned, 32'h0, 9'd0));
    idle_gap();
  endtask

  task automatic test_infinity_and_zero_kinds();
    send_beat(load_beat(0, 32'h8000_0000, 32'h8000_0000));
    send_beat(exec_beat(OpDiffSub, KSigned, KSigned, 32'h0, 9'd0));
    send_beat(exec_beat(OpDiffSub, KZero, KSigned, 32'h0, 9'd0));
    send_beat(exec_beat(OpDiffSub, KSigned, KPinf, 32'h0, 9'd0));
    send_beat(exec_beat(OpDiffAdd, KZero, KNinf, 32'h0, 9'd0));
    send_beat(exec_beat(OpDiffAddS, KZero, KSigned, 32'd5, 9'd0));
    send_beat(exec_beat(OpDiffSubS, KNinf, KSigned, 32'd5, 9'd0));
    send_beat(exec_beat(OpLt, KNinf, KPinf, 32'h0, 9'd0));
    send_beat(exec_beat(OpLe, KSigned, KUnsigned, 32'h0, 9'd0));
    send_beat(exec_beat(OpEq, KZero, KZero, 32'h0, 9'd0));
    send_beat(exec_beat(OpSign, KSigned, KZero, 32'h0, 9'd0));
    send_beat(exec_beat(OpAbs, KSigned, KZero, 32'h0, 9'd0));
    send_beat(exec_beat(OpAbs, KNinf, KZero, 32'h0, 9'd0));
    send_beat(exec_beat(OpKeyKey, 3'd7, 3'd5, 32'h0, 9'd0));
    send_beat(exec_beat(OpKeyAdd, KUnsigned, KPinf, 32'h0, 9'd0));
    send_beat(exec_beat(OpKeySub, KUnsigned, KZero, 32'h0, 9'd0));
    send_beat(exec_beat(OpKeySubS, KUnsigned, KZero, 32'd1, 9'd0));
    idle_gap();
  endtask

  task automatic test_random_sequences();
    int sent;
    int n;
    logic [31:0] w;
    sent = 0;
    while (sent < 300) begin
      if ($urandom_range(19) == 0) gaps_on = ~gaps_on;
      n = $urandom_range(Words);
      for (int i = 0; i < n; i++) begin
        w = pick_word();
        send_beat(load_beat($urandom_range(7), w,
                            ($urandom_range(3) == 0) ? w : pick_word()));
        idle_gap();
        sent++;
      end
      send_beat(exec_beat(4'($urandom_range(15)), 3'($urandom_range(7)),
                          3'($urandom_range(7)),
                          ($urandom_range(5) == 0) ? 32'h0 : pick_word(),
                          ($urandom_range(3) == 0) ? 9'($urandom) : 9'($urandom_range(170))));
      idle_gap();
      sent++;
    end
  endtask

  always @(posedge clk_i) begin
    res_beat_t e;
    if ((start && !busy) || result_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("ring_key_distance_alu_tb: FAIL");
      $finish;
    end
    if (rst_ni && result_valid_o) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result beat word %h", $time, result_word_o);
        fails++;
      end else begin
        e = expected_q.pop_front();
        if (e.word !== result_word_o || e.idx !== result_index_o || e.last !== last_o ||
            e.kind !== result_kind_o || e.flag !== flag_o || e.sgn !== sign_value_o ||
            e.err !== error_o) begin
          $display("%0t mismatch exp w=%h i=%0d l=%b k=%0d f=%b s=%b e=%0d", $time,
                   e.word, e.idx, e.last, e.kind, e.flag, e.sgn, e.err);
          $display("%0t          act w=%h i=%0d l=%b k=%0d f=%b s=%b e=%0d", $time,
                   result_word_o, result_index_o, last_o, result_kind_o, flag_o,
                   sign_value_o, error_o);
          fails++;
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extreme_words();
    test_infinity_and_zero_kinds();
    test_random_sequences();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (2 * Words + 10) @(posedge clk_i);
    if (fails == 0 && expected_q.size() == 0) begin
      $display("ring_key_distance_alu_tb: PASS");
    end else begin
      $display("ring_key_distance_alu_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
src/rkd_pkg.sv
src/rkd_front.sv
src/rkd_queue.sv
src/rkd_back.sv
src/ring_key_distance_alu.sv
test/ring_key_distance_alu_tb.sv
